FILE: src/spqa_pkg.sv
// Shared types and constants for the starvation-aging priority queue arbiter.
// No dependencies.
`default_nettype none

package spqa_pkg;

	// request and response codes
	localparam logic REQ_ENQ  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam int TAG_PORT_W = 16;
	localparam int PRIO_W     = 2;
	// level index field wide enough for the largest supported level count (8)
	localparam int LVL_W      = 3;

	typedef struct packed {
		logic             found;
		logic [LVL_W-1:0] level;
	} pick_t;

endpackage

`default_nettype wire

FILE: src/spqa_pick.sv
// Starvation compare: picks the non-empty level with the largest scaled count.
// Depends on spqa_pkg.
`default_nettype none

module spqa_pick #(
	parameter int LEVELS = 4
) (
	input  wire logic [LEVELS-1:0]                          nonempty,
	input  wire logic [LEVELS-1:0][2*(LEVELS-1):0]          cnt,
	output spqa_pkg::pick_t                                 pick
);

	localparam int CNT_W = 2*(LEVELS-1)+1;

	logic [CNT_W-1:0] best;
	logic [CNT_W-1:0] score;

	// scan high to low, replace only on strictly greater: ties go to the higher level
	always_comb begin
		pick  = '0;
		best  = '0;
		score = '0;
		for (int i = LEVELS-1; i >= 0; i--) begin
			score = CNT_W'(cnt[i] << (2*(LEVELS-1-i)));
			if (nonempty[i] && (!pick.found || score > best)) begin
				pick.found = 1'b1;
				pick.level = spqa_pkg::LVL_W'(i);
				best       = score;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/starvation_priority_queue_arbiter_top.sv
// Top level of the starvation-aging priority queue arbiter: per-level tag FIFOs,
// pass-over counters and the result register. Depends on spqa_pkg and spqa_pick.
`default_nettype none

// One word is taken on every clock where start is high; busy never rises, so the
// block sustains one request per cycle. Each request answers with done high for one cycle,
// once it has passed the input register and then the enqueue/compare logic into the
// result register, which is also the registered read port of the tag memory.
// The receiver cannot stall.
// The tag memory needs no clearing, so the block is ready straight out of reset.
module starvation_priority_queue_arbiter_top #(
	parameter int LEVELS     = 4,
	parameter int FIFO_DEPTH = 8,
	parameter int TAG_WIDTH  = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               req_type,
	input  wire logic [spqa_pkg::PRIO_W-1:0]        priority_req,
	input  wire logic [spqa_pkg::TAG_PORT_W-1:0]    packet_tag,
	output logic                                    done,
	output logic                                    resp_kind,
	output logic                                    accepted,
	output logic                                    grant_valid,
	output logic [spqa_pkg::PRIO_W-1:0]             grant_level,
	output logic [spqa_pkg::TAG_PORT_W-1:0]         grant_tag
);

	localparam int STORE_W = (TAG_WIDTH < spqa_pkg::TAG_PORT_W) ? TAG_WIDTH
	                                                            : spqa_pkg::TAG_PORT_W;
	localparam int LIDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W   = FILL_W + 1;
	localparam int ENTRIES = LEVELS * FIFO_DEPTH;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = 2*(LEVELS-1)+1;

	// input register
	logic                        valid_s1;
	logic                        type_s1;
	logic [spqa_pkg::PRIO_W-1:0] prio_s1;
	logic [STORE_W-1:0]          tag_s1;

	// result register
	logic                        valid_s2;
	logic                        kind_s2;
	logic                        acc_s2;
	logic                        gv_s2;
	logic [LIDX_W-1:0]           gl_s2;
	logic [STORE_W-1:0]          tag_s2;

	// queue state
	logic [STORE_W-1:0]                 mem [ENTRIES];
	logic [LEVELS-1:0][PTR_W-1:0]       head_q, head_d;
	logic [LEVELS-1:0][FILL_W-1:0]      fill_q, fill_d;
	logic [LEVELS-1:0][CNT_W-1:0]       cnt_q, cnt_d;

	logic [LEVELS-1:0] nonempty;
	spqa_pkg::pick_t   pick;
	logic [LIDX_W-1:0] pk;

	logic              is_enq, is_tick;
	logic              enq_ok;
	logic [PTR_W-1:0]  enq_head;
	logic [FILL_W-1:0] enq_fill;
	logic [SUM_W-1:0]  tail_sum;
	logic [PTR_W-1:0]  tail_slot;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [PTR_W-1:0]  pop_head;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			type_s1 <= req_type;
			prio_s1 <= priority_req;
			tag_s1  <= packet_tag[STORE_W-1:0];
		end
	end

	for (genvar g = 0; g < LEVELS; g++) begin : g_ne
		assign nonempty[g] = (fill_q[g] != '0);
	end

	spqa_pick #(
		.LEVELS (LEVELS)
	) u_pick (
		.nonempty (nonempty),
		.cnt      (cnt_q),
		.pick     (pick)
	);

	assign pk      = pick.level[LIDX_W-1:0];
	assign is_enq  = valid_s1 && (type_s1 == spqa_pkg::REQ_ENQ);
	assign is_tick = valid_s1 && (type_s1 == spqa_pkg::REQ_TICK);

	// enqueue side: level lookup without indexing past the array
	always_comb begin
		enq_head = '0;
		enq_fill = FILL_W'(FIFO_DEPTH);
		for (int l = 0; l < LEVELS; l++) begin
			if (int'(prio_s1) == l) begin
				enq_head = head_q[l];
				enq_fill = fill_q[l];
			end
		end
	end

	assign enq_ok    = is_enq && (enq_fill != FILL_W'(FIFO_DEPTH));
	assign tail_sum  = SUM_W'(enq_head) + SUM_W'(enq_fill);
	assign tail_slot = (tail_sum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH))
	                                                    : PTR_W'(tail_sum);
	assign wr_en     = enq_ok;
	assign wr_addr   = ADDR_W'(int'(prio_s1) * FIFO_DEPTH + int'(tail_slot));

	assign rd_en    = is_tick && pick.found;
	assign pop_head = head_q[pk];
	assign rd_addr  = ADDR_W'(int'(pk) * FIFO_DEPTH + int'(pop_head));

	always_comb begin
		head_d = head_q;
		fill_d = fill_q;
		cnt_d  = cnt_q;
		if (enq_ok) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (int'(prio_s1) == l) begin
					fill_d[l] = fill_q[l] + FILL_W'(1);
				end
			end
		end
		if (rd_en) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (LIDX_W'(l) == pk) begin
					cnt_d[l]  = '0;
					fill_d[l] = fill_q[l] - FILL_W'(1);
					head_d[l] = (head_q[l] == PTR_W'(FIFO_DEPTH-1)) ? '0
					                                               : head_q[l] + PTR_W'(1);
				end else if (nonempty[l] && (cnt_q[l] < CNT_W'(1 << (2*l)))) begin
					cnt_d[l] = cnt_q[l] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			fill_q   <= '0;
			cnt_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			head_q   <= head_d;
			fill_q   <= fill_d;
			cnt_q    <= cnt_d;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2 <= type_s1;
			acc_s2  <= enq_ok;
			gv_s2   <= rd_en;
			gl_s2   <= rd_en ? pk : '0;
		end
	end

	// tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_s2 <= mem[rd_addr];
		end
	end

	assign done        = valid_s2;
	assign resp_kind   = valid_s2 ? kind_s2 : 1'b0;
	assign accepted    = valid_s2 && acc_s2;
	assign grant_valid = valid_s2 && gv_s2;
	assign grant_level = grant_valid ? spqa_pkg::PRIO_W'(gl_s2) : '0;
	assign grant_tag   = grant_valid ? spqa_pkg::TAG_PORT_W'(tag_s2) : '0;

	// every taken word answers with done after the input and result registers
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("request did not answer after two cycles");

	a_grant_kind : assert property (@(posedge clk) disable iff (!arst_n)
		done && (grant_valid || accepted) |->
			(grant_valid && resp_kind == spqa_pkg::REQ_TICK) ||
			(accepted && resp_kind == spqa_pkg::REQ_ENQ))
		else $error("grant or accept flag on wrong response kind");

	// served level restarts its pass-over count
	a_served_cleared : assert property (@(posedge clk) disable iff (!arst_n)
		done && grant_valid |-> cnt_q[gl_s2] == '0)
		else $error("served level counter not cleared");

	a_pop_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> nonempty[pk])
		else $error("pop from empty level");

	for (genvar g = 0; g < LEVELS; g++) begin : g_chk
		a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
			fill_q[g] <= FILL_W'(FIFO_DEPTH) && cnt_q[g] <= CNT_W'(1 << (2*g)))
			else $error("fill or counter out of range");
	end

endmodule

`default_nettype wire
